### rtl/pidar_pkg.sv
// Shared types and constants for the PID angle regulator.
// Used by the controller, the datapath and the top level; depends on nothing.
package pidar_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ANGLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_WINDOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 3'd5;

    localparam logic [30:0] RST_INTEG_WINDOW = 31'd196608;
    localparam logic [14:0] RST_OUTPUT_LIMIT = 15'd1000;

    // Restoring divider: one quotient bit per cycle over a 68-bit dividend.
    localparam int DIV_STEPS = 68;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [31:0] US_PER_S = 32'd1000000;

    typedef struct packed {
        logic capture;
        logic prep;
        logic mul_p;
        logic mul_i;
        logic mul_d;
        logic dmag;
        logic mul_lo;
        logic mul_hi;
        logic num;
        logic div_step;
        logic sum;
        logic add;
        logic load;
    } pidar_cmd_t;

    typedef struct packed {
        logic div_last;
    } pidar_sts_t;

endpackage

### rtl/pidar_ctrl.sv
// Sequencer for the PID angle regulator: one-hot state machine that steps the
// datapath through its multiplies, division and summation. Depends on pidar_pkg.
module pidar_ctrl import pidar_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  pidar_sts_t sts,
    output pidar_cmd_t cmd
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_PREP   = 13'b0000000000010,
        S_MUL_P  = 13'b0000000000100,
        S_MUL_I  = 13'b0000000001000,
        S_MUL_D  = 13'b0000000010000,
        S_DMAG   = 13'b0000000100000,
        S_MUL_LO = 13'b0000001000000,
        S_MUL_HI = 13'b0000010000000,
        S_NUM    = 13'b0000100000000,
        S_DIV    = 13'b0001000000000,
        S_SUM    = 13'b0010000000000,
        S_ADD    = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } pidar_state_t;

    pidar_state_t state_reg;
    pidar_state_t state_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.capture  = (state_reg == S_IDLE) && in_valid;
        cmd.prep     = (state_reg == S_PREP);
        cmd.mul_p    = (state_reg == S_MUL_P);
        cmd.mul_i    = (state_reg == S_MUL_I);
        cmd.mul_d    = (state_reg == S_MUL_D);
        cmd.dmag     = (state_reg == S_DMAG);
        cmd.mul_lo   = (state_reg == S_MUL_LO);
        cmd.mul_hi   = (state_reg == S_MUL_HI);
        cmd.num      = (state_reg == S_NUM);
        cmd.div_step = (state_reg == S_DIV);
        cmd.sum      = (state_reg == S_SUM);
        cmd.add      = (state_reg == S_ADD);
        cmd.load     = (state_reg == S_OUT) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:   state_next = S_MUL_P;
            S_MUL_P:  state_next = S_MUL_I;
            S_MUL_I:  state_next = S_MUL_D;
            S_MUL_D:  state_next = S_DMAG;
            S_DMAG:   state_next = S_MUL_LO;
            S_MUL_LO: state_next = S_MUL_HI;
            S_MUL_HI: state_next = S_NUM;
            S_NUM:    state_next = S_DIV;
            S_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:    state_next = S_ADD;
            S_ADD:    state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // The output word holds until taken; a finished result waits in S_OUT meanwhile.
    always_comb
    begin
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/pidar_dp.sv
// Datapath of the PID angle regulator: configuration registers, loop state,
// a shared 34x32 multiplier, a serial divider and the output register.
// Depends on pidar_pkg.
module pidar_dp import pidar_pkg::*;
#(
    parameter int INTEG_BITS = 48
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic signed [31:0]    measured_angle,
    input  logic [19:0]           elapsed_us,
    input  pidar_cmd_t            cmd,
    output pidar_sts_t            sts,
    output logic signed [15:0]    drive,
    output logic                  clamped
);

    localparam int INC_W = 49;
    localparam int AW    = ((INTEG_BITS > INC_W) ? INTEG_BITS : INC_W) + 1;
    localparam logic signed [AW-1:0] I_HI =
        {{(AW-INTEG_BITS+1){1'b0}}, {(INTEG_BITS-1){1'b1}}};
    localparam logic signed [AW-1:0] I_LO =
        {{(AW-INTEG_BITS+1){1'b1}}, {(INTEG_BITS-1){1'b0}}};
    localparam logic signed [64:0] CAP_POS = 65'sd1 <<< 60;
    localparam logic signed [64:0] CAP_NEG = -CAP_POS;
    localparam logic [67:0]        Q_CAP   = 68'd1 << 60;

    // Configuration registers.
    logic signed [31:0] prop_gain_reg;
    logic signed [31:0] integ_gain_reg;
    logic signed [31:0] deriv_gain_reg;
    logic signed [31:0] target_angle_reg;
    logic [30:0]        integ_window_reg;
    logic [14:0]        output_limit_reg;

    // Loop state.
    logic signed [32:0]           last_err_reg;
    logic signed [INTEG_BITS-1:0] isum_reg;
    logic signed [INTEG_BITS-1:0] isum_next;
    logic signed [AW-1:0]         isum_wide;

    // Working registers.
    logic signed [32:0] err_reg;
    logic [19:0]        el_reg;
    logic [32:0]        err_mag_reg;
    logic               err_neg_reg;
    logic signed [33:0] diff_reg;
    logic [33:0]        diff_mag_reg;
    logic               diff_neg_reg;
    logic               in_win_reg;
    logic [31:0]        pg_mag_reg;
    logic [31:0]        ig_mag_reg;
    logic [31:0]        dg_mag_reg;
    logic [65:0]        prod_reg;
    logic signed [48:0] p_reg;
    logic signed [48:0] inc_reg;
    logic [63:0]        dmag_reg;
    logic               dneg_reg;
    logic [51:0]        num_lo_reg;
    logic [67:0]        dq_reg;
    logic [19:0]        rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic signed [61:0] d_reg;
    logic signed [61:0] icap_reg;
    logic signed [63:0] sum_reg;
    logic signed [15:0] drive_reg;
    logic               clamped_reg;

    logic [33:0]        mul_a;
    logic [31:0]        mul_b;
    logic [48:0]        p_mag;
    logic [48:0]        inc_mag;
    logic [83:0]        num_wide;
    logic [20:0]        trial;
    logic [20:0]        trial_sub;
    logic               trial_ge;
    logic [60:0]        dcap;
    logic signed [64:0] isum_ext;
    logic signed [63:0] sum_bias;
    logic signed [47:0] pid_int;
    logic signed [47:0] lim_pos;
    logic signed [47:0] lim_neg;

    assign drive        = drive_reg;
    assign clamped      = clamped_reg;
    assign sts.div_last = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg    <= '0;
            integ_gain_reg   <= '0;
            deriv_gain_reg   <= '0;
            target_angle_reg <= '0;
            integ_window_reg <= RST_INTEG_WINDOW;
            output_limit_reg <= RST_OUTPUT_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PROP_GAIN:    prop_gain_reg    <= cfg_data;
                CFG_INTEG_GAIN:   integ_gain_reg   <= cfg_data;
                CFG_DERIV_GAIN:   deriv_gain_reg   <= cfg_data;
                CFG_TARGET_ANGLE: target_angle_reg <= cfg_data;
                CFG_INTEG_WINDOW: integ_window_reg <= cfg_data[30:0];
                CFG_OUTPUT_LIMIT: output_limit_reg <= cfg_data[14:0];
                default:          ;
            endcase
        end
    end

    // Saturating integral update on the exact, widened sum.
    always_comb
    begin
        isum_wide = AW'(isum_reg) + AW'(inc_reg);
        if (isum_wide > I_HI)
        begin
            isum_next = I_HI[INTEG_BITS-1:0];
        end
        else if (isum_wide < I_LO)
        begin
            isum_next = I_LO[INTEG_BITS-1:0];
        end
        else
        begin
            isum_next = isum_wide[INTEG_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_err_reg <= '0;
            isum_reg     <= '0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.prep)
            begin
                last_err_reg <= err_reg;
            end
            if (cmd.dmag && in_win_reg)
            begin
                isum_reg <= isum_next;
            end
            if (cmd.num)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
        end
    end

    // Shared unsigned multiplier operands; every product is of magnitudes.
    always_comb
    begin
        if (cmd.mul_p || cmd.mul_i)
        begin
            mul_a = {1'b0, err_mag_reg};
        end
        else if (cmd.mul_d)
        begin
            mul_a = diff_mag_reg;
        end
        else if (cmd.mul_lo)
        begin
            mul_a = {2'b00, dmag_reg[31:0]};
        end
        else
        begin
            mul_a = {2'b00, dmag_reg[63:32]};
        end

        if (cmd.mul_p)
        begin
            mul_b = pg_mag_reg;
        end
        else if (cmd.mul_i)
        begin
            mul_b = ig_mag_reg;
        end
        else if (cmd.mul_d)
        begin
            mul_b = dg_mag_reg;
        end
        else
        begin
            mul_b = US_PER_S;
        end
    end

    always_comb
    begin
        p_mag     = {1'b0, prod_reg[63:16]};
        inc_mag   = {1'b0, prod_reg[63:16]};
        num_wide  = {prod_reg[51:0], 32'd0} + {32'd0, num_lo_reg};
        trial     = {rem_reg, dq_reg[67]};
        trial_sub = trial - {1'b0, el_reg};
        trial_ge  = (trial >= {1'b0, el_reg});
        dcap      = (dq_reg > Q_CAP) ? Q_CAP[60:0] : dq_reg[60:0];
        isum_ext  = 65'(isum_reg);
        // Adding 2^16 - 1 to a negative sum makes the shift truncate toward zero.
        sum_bias  = sum_reg + (sum_reg[63] ? 64'sd65535 : 64'sd0);
        pid_int   = sum_bias[63:16];
        lim_pos   = {33'd0, output_limit_reg};
        lim_neg   = 48'sd0 - lim_pos;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            err_reg <= 33'(measured_angle) - 33'(target_angle_reg);
            el_reg  <= (elapsed_us == 20'd0) ? 20'd1 : elapsed_us;
        end
        if (cmd.prep)
        begin
            err_mag_reg <= err_reg[32] ? (33'd0 - err_reg) : err_reg;
            err_neg_reg <= err_reg[32];
            diff_reg    <= 34'(err_reg) - 34'(last_err_reg);
            pg_mag_reg  <= prop_gain_reg[31] ? (32'd0 - prop_gain_reg) : prop_gain_reg;
            ig_mag_reg  <= integ_gain_reg[31] ? (32'd0 - integ_gain_reg) : integ_gain_reg;
            dg_mag_reg  <= deriv_gain_reg[31] ? (32'd0 - deriv_gain_reg) : deriv_gain_reg;
        end
        if (cmd.mul_p)
        begin
            diff_mag_reg <= diff_reg[33] ? (34'd0 - diff_reg) : diff_reg;
            diff_neg_reg <= diff_reg[33];
            in_win_reg   <= (err_mag_reg < {2'b00, integ_window_reg});
        end
        if (cmd.mul_p || cmd.mul_i || cmd.mul_d || cmd.mul_lo || cmd.mul_hi)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.mul_i)
        begin
            p_reg <= (prop_gain_reg[31] ^ err_neg_reg) ? (49'd0 - p_mag) : p_mag;
        end
        if (cmd.mul_d)
        begin
            inc_reg <= (integ_gain_reg[31] ^ err_neg_reg) ? (49'd0 - inc_mag) : inc_mag;
        end
        if (cmd.dmag)
        begin
            dmag_reg <= prod_reg[63:0];
            dneg_reg <= deriv_gain_reg[31] ^ diff_neg_reg;
        end
        if (cmd.mul_hi)
        begin
            num_lo_reg <= prod_reg[51:0];
        end
        // The dividend is the scaled product over 2^16; the divisor is the elapsed time.
        if (cmd.num)
        begin
            dq_reg  <= num_wide[83:16];
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dq_reg  <= {dq_reg[66:0], trial_ge};
            rem_reg <= trial_ge ? trial_sub[19:0] : trial[19:0];
        end
        if (cmd.sum)
        begin
            d_reg <= dneg_reg ? (62'd0 - {1'b0, dcap}) : {1'b0, dcap};
            if (isum_ext > CAP_POS)
            begin
                icap_reg <= CAP_POS[61:0];
            end
            else if (isum_ext < CAP_NEG)
            begin
                icap_reg <= CAP_NEG[61:0];
            end
            else
            begin
                icap_reg <= isum_ext[61:0];
            end
        end
        if (cmd.add)
        begin
            sum_reg <= 64'(p_reg) + 64'(icap_reg) + 64'(d_reg);
        end
        if (cmd.load)
        begin
            if (pid_int > lim_pos)
            begin
                drive_reg   <= lim_pos[15:0];
                clamped_reg <= 1'b1;
            end
            else if (pid_int < lim_neg)
            begin
                drive_reg   <= lim_neg[15:0];
                clamped_reg <= 1'b1;
            end
            else
            begin
                drive_reg   <= pid_int[15:0];
                clamped_reg <= 1'b0;
            end
        end
    end

endmodule

### rtl/pid_angle_regulator_core.sv
// PID angle regulator: a new word is accepted only in idle, which the block reaches once
// the result of the last word has been loaded into the free output register.
// The work runs through the 68-step restoring divider and the shared multiplier,
// which serves five products in turn. Reset is asynchronous and active low; it
// restores the register defaults and clears the error history and the integral.
module pid_angle_regulator_core import pidar_pkg::*;
#(
    parameter int INTEG_BITS = 48
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [31:0]    measured_angle,
    input  logic [19:0]           elapsed_us,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [15:0]    drive,
    output logic                  clamped
);

    pidar_cmd_t cmd;
    pidar_sts_t sts;

    pidar_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pidar_dp #(
        .INTEG_BITS (INTEG_BITS)
    ) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .measured_angle (measured_angle),
        .elapsed_us     (elapsed_us),
        .cmd            (cmd),
        .sts            (sts),
        .drive          (drive),
        .clamped        (clamped)
    );

endmodule

### rtl/pidar_checker.sv
// Port-level checks for the PID angle regulator, attached by bind.
// Depends only on the top level's ports.
module pidar_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] drive,
    input logic               clamped
);

    // One word at a time: the block is busy right after taking a word.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a word was in flight");

    // A result appears exactly as the block returns to idle.
    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result presented without returning to idle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(clamped))
        else $error("stalled result changed or vanished");

    // The clamp is symmetric, so the most negative code can never be produced.
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> drive != 16'sh8000)
        else $error("drive outside the symmetric range");

endmodule

bind pid_angle_regulator_core pidar_checker u_pidar_checker (.*);

### dv/testbench.sv
// Self-checking testbench for pid_angle_regulator_core: directed angle samples, then random
// settings phases with idle gaps and back-pressure on both handshakes.
// Depends on pidar_pkg and the regulator RTL only.
`timescale 1ns / 1ps

module testbench;
    import pidar_pkg::*;

    localparam int              ACC_BITS     = 48;
    localparam longint          ACC_MAX      = (longint'(1) <<< (ACC_BITS - 1)) - 1;
    localparam longint          ACC_MIN      = -ACC_MAX - 1;
    localparam longint          TERM_LIM     = longint'(1) <<< 60;
    localparam longint unsigned TERM_LIM_U   = 64'd1 << 60;
    localparam longint unsigned USEC_PER_SEC = 64'd1000000;
    localparam int              HOLD_CYCLES  = 600;
    localparam int              CYCLE_LIMIT  = 4000000;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               clamped;
    } drive_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [31:0]           measured_angle;
    logic [19:0]           elapsed_us;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [15:0]    drive;
    logic                  clamped;

    // Mirror of the register file and of the regulator's history.
    longint gain_p    = 0;
    longint gain_i    = 0;
    longint gain_d    = 0;
    longint set_angle = 0;
    longint win       = longint'(RST_INTEG_WINDOW);
    longint lim       = longint'(RST_OUTPUT_LIMIT);
    longint prev_err  = 0;
    longint integ_acc = 0;

    drive_word_t pending_drive[$];
    int          err_count   = 0;
    int          words_seen  = 0;
    int          cycle_count = 0;
    int          sink_stall  = 0;
    int          hold_req    = 0;
    int          hold_seen   = 0;
    bit          src_calm    = 1'b0;
    bit          sink_calm   = 1'b0;

    pid_angle_regulator_core #(.INTEG_BITS(ACC_BITS)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .measured_angle (measured_angle),
        .elapsed_us     (elapsed_us),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive          (drive),
        .clamped        (clamped)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint unsigned abs64(input longint x);
        return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    function automatic longint signed_mag(input longint unsigned m, input bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clip_term(input longint v);
        if (v > TERM_LIM)
            return TERM_LIM;
        if (v < -TERM_LIM)
            return -TERM_LIM;
        return v;
    endfunction

    // Works out the drive word for one sample and advances the error history
    // and the integral exactly as the regulator does.
    function automatic drive_word_t predict_drive(input logic [31:0] angle,
                                                  input logic [19:0] usec);
        longint          err;
        longint          diff;
        longint          p_term;
        longint          step;
        longint          d_term;
        longint          total;
        longint          pid;
        longint unsigned m;
        longint unsigned el;
        longint unsigned den;
        longint unsigned q;
        longint unsigned r;
        bit              clip;
        drive_word_t     w;

        el  = (usec == 20'd0) ? 64'd1 : 64'(usec);
        err = longint'(signed'(angle)) - set_angle;

        m      = (abs64(gain_p) * abs64(err)) >> 16;
        p_term = signed_mag(m, (gain_p < 0) != (err < 0));

        // An error exactly on the window edge is left out of the integral.
        if (longint'(abs64(err)) < win)
        begin
            m    = (abs64(gain_i) * abs64(err)) >> 16;
            step = signed_mag(m, (gain_i < 0) != (err < 0));
            if (step > 0 && integ_acc > ACC_MAX - step)
                integ_acc = ACC_MAX;
            else if (step < 0 && integ_acc < ACC_MIN - step)
                integ_acc = ACC_MIN;
            else
                integ_acc = integ_acc + step;
        end

        diff = err - prev_err;
        m    = abs64(gain_d) * abs64(diff);
        den  = el << 16;
        q    = m / den;
        r    = m % den;
        if (q > TERM_LIM_U / USEC_PER_SEC)
        begin
            m = TERM_LIM_U;
        end
        else
        begin
            m = q * USEC_PER_SEC + (r * USEC_PER_SEC) / den;
            if (m > TERM_LIM_U)
                m = TERM_LIM_U;
        end
        d_term = signed_mag(m, (gain_d < 0) != (diff < 0));

        total = clip_term(p_term) + clip_term(integ_acc) + d_term;
        pid   = signed_mag(abs64(total) >> 16, total < 0);
        clip  = 1'b0;
        if (pid > lim)
        begin
            pid  = lim;
            clip = 1'b1;
        end
        if (pid < -lim)
        begin
            pid  = -lim;
            clip = 1'b1;
        end
        prev_err = err;

        w.drive   = 16'(pid);
        w.clamped = clip;
        return w;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 4);
        return $urandom_range(20, 250);
    endfunction

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            default: return 32'($signed($urandom) >>> $urandom_range(10, 30));
        endcase
    endfunction

    function automatic logic [31:0] rand_target();
        case ($urandom_range(0, 3))
            0:       return 32'h0;
            1:       return $urandom;
            default: return 32'($signed($urandom) >>> $urandom_range(6, 16));
        endcase
    endfunction

    function automatic logic [31:0] rand_window();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return 32'h0;
        else if (pick < 20)
            return 32'h7FFF_FFFF;
        return $urandom_range(1, 32'h0040_0000);
    endfunction

    function automatic logic [31:0] rand_limit();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'd32767;
            2:       return $urandom_range(1, 200);
            default: return $urandom_range(1, 32767);
        endcase
    endfunction

    // Most samples sit near the setpoint so that the window and the clamp both matter.
    function automatic logic [31:0] rand_angle();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return 32'(set_angle) + 32'($signed($urandom) >>> $urandom_range(8, 24));
        else if (pick < 90)
            return $urandom;
        case ($urandom_range(0, 4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'(set_angle);
            3:       return 32'(set_angle + win);
            default: return 32'(set_angle - win);
        endcase
    endfunction

    function automatic logic [19:0] rand_elapsed();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return 20'($urandom_range(200, 20000));
        else if (pick < 85)
            return 20'($urandom_range(0, 8));
        return 20'($urandom_range(0, 20'hFFFFF));
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 100)
            $display("ERROR: word %0d: %s", words_seen, msg);
    endtask

    task automatic check_drive_word(input logic signed [15:0] got_drive,
                                    input logic got_clamped);
        drive_word_t want;
        if (pending_drive.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word, drive %0d clamped %0b",
                                      got_drive, got_clamped));
        end
        else
        begin
            want = pending_drive.pop_front();
            if (got_drive !== want.drive)
                report_mismatch($sformatf("drive %0d, expected %0d", got_drive, want.drive));
            if (got_clamped !== want.clamped)
                report_mismatch($sformatf("clamped %0b, expected %0b",
                                          got_clamped, want.clamped));
        end
        words_seen++;
    endtask

    // Result side: random stalls, calm stretches, and the long hold on request.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            check_drive_word(drive, clamped);
        end
        if (hold_req != hold_seen)
        begin
            hold_seen  = hold_req;
            sink_stall = HOLD_CYCLES;
        end
        else if (sink_stall > 0)
        begin
            sink_stall--;
        end
        else if (!sink_calm && $urandom_range(0, 99) < 20)
        begin
            sink_stall = pick_gap();
        end
        out_ready <= (sink_stall == 0);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_sample(input logic [31:0] angle, input logic [19:0] usec);
        int gap;
        in_valid       <= 1'b1;
        measured_angle <= angle;
        elapsed_us     <= usec;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        pending_drive.push_back(predict_drive(angle, usec));
        gap = (src_calm || $urandom_range(0, 99) >= 40) ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_drive.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_PROP_GAIN:    gain_p    = longint'(signed'(value));
            CFG_INTEG_GAIN:   gain_i    = longint'(signed'(value));
            CFG_DERIV_GAIN:   gain_d    = longint'(signed'(value));
            CFG_TARGET_ANGLE: set_angle = longint'(signed'(value));
            CFG_INTEG_WINDOW: win       = longint'(value[30:0]);
            CFG_OUTPUT_LIMIT: lim       = longint'(value[14:0]);
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [31:0] pg, input logic [31:0] ig,
                                 input logic [31:0] dg, input logic [31:0] tg,
                                 input logic [31:0] wn, input logic [31:0] ol);
        wait_drained();
        put_reg(CFG_PROP_GAIN, pg);
        put_reg(CFG_INTEG_GAIN, ig);
        put_reg(CFG_DERIV_GAIN, dg);
        put_reg(CFG_TARGET_ANGLE, tg);
        put_reg(CFG_INTEG_WINDOW, wn);
        put_reg(CFG_OUTPUT_LIMIT, ol);
        cfg_we <= 1'b0;
    endtask

    // Unit gains against the reset window of 3.0 and the reset limit of 1000.
    task automatic test_reset_state();
        put_reg(CFG_PROP_GAIN, 32'h0001_0000);
        put_reg(CFG_INTEG_GAIN, 32'h0001_0000);
        cfg_we <= 1'b0;
        send_sample(32'h0002_0000, 20'd1000);
        send_sample(32'h0003_0000, 20'd1000);
        send_sample(32'h07D0_0000, 20'd1000);
        send_sample(32'hEC78_0000, 20'd1000);
    endtask

    // Largest error with the largest gain against a zero limit.
    task automatic test_proportional_limits();
        load_settings(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0);
        send_sample(32'h7FFF_FFFF, 20'd1);
        send_sample(32'h8000_0000, 20'hFFFFF);
        send_sample(32'h8064_0000, 20'd0);
    endtask

    // Drives the integral into saturation at both ends, checks both window edges,
    // then brings it back to a small known value.
    task automatic test_integral_saturation();
        load_settings(32'h0, 32'h4000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'd32767);
        repeat (5) send_sample(32'h7FFF_FFFE, 20'd500);
        send_sample(32'h7FFF_FFFF, 20'd500);
        send_sample(32'h8000_0001, 20'd500);
        load_settings(32'h0, 32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'd32767);
        repeat (5) send_sample(32'h7FFF_FFFE, 20'd500);
        repeat (2) send_sample(32'h8000_0002, 20'd500);
    endtask

    task automatic test_derivative();
        load_settings(32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'd196608, 32'd32767);
        send_sample(32'h0001_0000, 20'd0);
        send_sample(32'h0001_0000, 20'hFFFFF);
        send_sample(32'h7FFF_FFFF, 20'd1);
        send_sample(32'h8000_0000, 20'd1);
        load_settings(32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'd196608, 32'd32767);
        send_sample(32'h000A_0000, 20'd1000);
        send_sample(32'h000A_0001, 20'hFFFFF);
    endtask

    task automatic test_random_settings(input int phases, input int per_phase);
        for (int ph = 0; ph < phases; ph++)
        begin
            load_settings(rand_gain(), rand_gain(), rand_gain(), rand_target(),
                          rand_window(), rand_limit());
            src_calm  = ($urandom_range(0, 4) == 0);
            sink_calm = ($urandom_range(0, 4) == 0);
            for (int n = 0; n < per_phase; n++)
            begin
                send_sample(rand_angle(), rand_elapsed());
            end
        end
    endtask

    // The result side holds off while words keep coming, so the input stalls.
    task automatic test_backpressure();
        src_calm = 1'b1;
        hold_req++;
        repeat (12) send_sample(rand_angle(), rand_elapsed());
        src_calm = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_PROP_GAIN;
        cfg_data       = '0;
        in_valid       = 1'b0;
        measured_angle = '0;
        elapsed_us     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_proportional_limits();
        test_integral_saturation();
        test_derivative();
        test_random_settings(8, 100);
        test_backpressure();
        test_random_settings(8, 100);

        wait_drained();
        repeat (100) @(posedge clk);
        if (err_count == 0 && pending_drive.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
